// ----- rtl/kms_pkg.sv -----
// Shared types and constants of the keyboard matrix event scanner.
package kms_pkg;

  // Layer key position in the matrix.
  localparam int LK_ROW = 7;
  localparam int LK_COL = 6;

  // Column field is three bits wide, so at most eight lanes ever see data.
  localparam int MAX_COLS = 8;
  localparam int COL_W    = 3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ESCAPE = 2'd0;
  localparam logic [1:0] CFG_TILDE  = 2'd1;
  localparam logic [1:0] CFG_LSHIFT = 2'd2;
  localparam logic [1:0] CFG_RSHIFT = 2'd3;

  // Configuration reset values.
  localparam logic [7:0] ESCAPE_RST = 8'd41;
  localparam logic [7:0] TILDE_RST  = 8'd53;
  localparam logic [7:0] LSHIFT_RST = 8'd225;
  localparam logic [7:0] RSHIFT_RST = 8'd229;

  // Input item opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  // Result item kinds.
  localparam logic KIND_KEY    = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  // What one column lane reports for the current row.
  typedef struct packed {
    logic chg;    // key state differs from the stored map
    logic now;    // new pressed state
    logic layer;  // keymap layer in force when this key is looked up
  } lane_t;

  // Lowest changed column picked by the merge stage.
  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] col;
    logic             now;
    logic             layer;
    logic             more;   // further changed columns remain after this one
  } pick_t;

endpackage

// ----- rtl/kms_lane.sv -----
// One column lane: change detection and layer selection for one key of the row.
module kms_lane #(
  parameter int J = 0
) (
  input  logic            col_bit_i,
  input  logic            old_bit_i,
  input  logic            lk_old_i,
  input  logic            lk_new_i,
  input  logic            row_is_lk_i,
  output kms_pkg::lane_t  lane_o
);

  localparam bit AfterLk = (J > kms_pkg::LK_COL);

  always_comb begin
    lane_o.now   = ~col_bit_i;
    lane_o.chg   = (~col_bit_i) ^ old_bit_i;
    // keys right of the layer key in its own row see its new state
    lane_o.layer = (AfterLk && row_is_lk_i) ? lk_new_i : lk_old_i;
  end

endmodule

// ----- rtl/kms_merge.sv -----
// Merge stage: picks the lowest changed column of the lanes still pending.
module kms_merge #(
  parameter int NL = 8
) (
  input  kms_pkg::lane_t lanes_i [NL],
  output kms_pkg::pick_t pick_o
);

  localparam int CW3 = kms_pkg::COL_W;

  always_comb begin
    pick_o = '0;
    for (int j = NL - 1; j >= 0; j--) begin
      if (lanes_i[j].chg) begin
        pick_o.found = 1'b1;
        pick_o.col   = CW3'(j);
        pick_o.now   = lanes_i[j].now;
        pick_o.layer = lanes_i[j].layer;
      end
    end
    for (int j = 0; j < NL; j++) begin
      if (lanes_i[j].chg && (CW3'(j) != pick_o.col)) begin
        pick_o.more = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/kms_keymap.sv -----
// Keymap store: one write port, one registered read port.
module kms_keymap #(
  parameter int AW = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/keyboard_matrix_event_scanner.sv -----
// Keyboard matrix event scanner: top level with pressed map, sequencer and output stage.
//
// Input channel (in_valid_i/in_ready_o) takes one item at a time. A load item
// (opcode 0) writes one keymap entry and leaves the scanner idle, with no result.
// A scan item (opcode 1) carries one row of active-low column readings; every
// key whose state changed gives a press or release result, and after the last
// row a commit marker follows if anything changed since the previous marker.
// The final result of an item has last_o set.
// A scan item gives one result per changed key, one more per escape release
// (tilde release goes first) and one for a commit marker. Each changed key takes
// one lookup on the single keymap read port, and the output register takes one
// result per cycle unless the receiver stalls.
// Results leave through an output register (out_valid_o/out_ready_i); when the
// receiver stalls, the sequencer holds its place until the register frees.
// Configuration writes (cfg_we_i) land at once; the user must make them while idle, unchecked.
// Reset releases all keys, clears the shift flags and change flag, and loads
// the default codes; keymap contents are undefined until loaded.
module keyboard_matrix_event_scanner #(
  parameter int ROWS   = 8,
  parameter int COLS   = 8,
  parameter int LAYERS = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic       layer_sel_i,
  input  logic [2:0] row_index_i,
  input  logic [2:0] col_index_i,
  input  logic [7:0] entry_code_i,
  input  logic [7:0] column_bits_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] key_code_o,
  output logic       pressed_o,
  output logic       last_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int NL = (COLS < kms_pkg::MAX_COLS) ? COLS : kms_pkg::MAX_COLS;
  localparam int CW = (NL > 1) ? $clog2(NL) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int AW = LW + RW + CW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_ESC    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_q, state_d;

  logic [7:0] esc_q, tilde_q, lsc_q, rsc_q;
  logic       lshift_q, rshift_q;
  logic       pass_chg_q, commit_q;
  logic       cur_now_q, more_q;
  logic [RW-1:0] row_q;

  logic [NL-1:0]  map_q [ROWS];
  kms_pkg::lane_t lane_q [NL];
  kms_pkg::lane_t lane_w [NL];
  kms_pkg::pick_t pick;

  logic       out_valid_q, kind_q, pressed_q, last_q;
  logic [7:0] code_q;

  logic          accept, load_ok, row_ok, scan_go;
  logic [RW-1:0] row_idx;
  logic [NL-1:0] old_row;
  logic          lk_old, lk_new, row_is_lk, any_chg, last_row;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;

  logic       out_free, emit, e_kind, e_pressed, e_last, lane_clr;
  logic [7:0] e_code;

  assign accept  = in_valid_i && in_ready_o;
  assign row_idx = RW'(row_index_i);
  assign row_ok  = int'(row_index_i) < ROWS;
  assign load_ok = (int'(layer_sel_i) < LAYERS) && row_ok && (int'(col_index_i) < COLS);
  assign scan_go = accept && (opcode_i == kms_pkg::OP_SCAN) && row_ok;
  assign old_row = row_ok ? map_q[row_idx] : '0;
  assign last_row = int'(row_index_i) == (ROWS - 1);

  generate
    if (ROWS > kms_pkg::LK_ROW && COLS > kms_pkg::LK_COL && LAYERS > 1) begin : g_lk
      assign lk_old    = map_q[kms_pkg::LK_ROW][kms_pkg::LK_COL];
      assign lk_new    = ~column_bits_i[kms_pkg::LK_COL];
      assign row_is_lk = int'(row_index_i) == kms_pkg::LK_ROW;
    end else begin : g_nolk
      assign lk_old    = 1'b0;
      assign lk_new    = 1'b0;
      assign row_is_lk = 1'b0;
    end
  endgenerate

  for (genvar j = 0; j < NL; j++) begin : g_lane
    kms_lane #(.J(j)) u_lane (
      .col_bit_i   (column_bits_i[j]),
      .old_bit_i   (old_row[j]),
      .lk_old_i    (lk_old),
      .lk_new_i    (lk_new),
      .row_is_lk_i (row_is_lk),
      .lane_o      (lane_w[j])
    );
  end

  always_comb begin
    any_chg = 1'b0;
    for (int j = 0; j < NL; j++) begin
      any_chg = any_chg | lane_w[j].chg;
    end
  end

  kms_merge #(.NL(NL)) u_merge (
    .lanes_i (lane_q),
    .pick_o  (pick)
  );

  assign mem_we = accept && (opcode_i == kms_pkg::OP_LOAD) && load_ok;
  assign waddr  = {LW'(layer_sel_i), row_idx, CW'(col_index_i)};
  assign mem_re = (state_q == S_FIND) && pick.found;
  assign raddr  = {LW'(pick.layer), row_q, pick.col[CW-1:0]};

  kms_keymap #(.AW(AW)) u_keymap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (entry_code_i),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // sequencer: one keymap lookup per changed key; results wait while the output register is full
  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    e_kind    = kms_pkg::KIND_KEY;
    e_code    = rdata;
    e_pressed = 1'b0;
    e_last    = !more_q && !commit_q;
    lane_clr  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (scan_go) state_d = S_FIND;
      end
      S_FIND: begin
        if (pick.found) begin
          lane_clr = 1'b1;
          state_d  = S_READ;
        end else if (commit_q) begin
          state_d = S_COMMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          emit = 1'b1;
          if (cur_now_q) begin
            e_pressed = 1'b1;
            if (rdata == esc_q && (lshift_q || rshift_q)) e_code = tilde_q;
            state_d = S_FIND;
          end else if (rdata == esc_q) begin
            // escape release: tilde release first
            e_code  = tilde_q;
            e_last  = 1'b0;
            state_d = S_ESC;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      S_ESC: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_FIND;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = kms_pkg::KIND_COMMIT;
          e_code  = '0;
          e_last  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= kms_pkg::ESCAPE_RST;
      tilde_q <= kms_pkg::TILDE_RST;
      lsc_q   <= kms_pkg::LSHIFT_RST;
      rsc_q   <= kms_pkg::RSHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kms_pkg::CFG_ESCAPE: esc_q   <= cfg_data_i;
        kms_pkg::CFG_TILDE:  tilde_q <= cfg_data_i;
        kms_pkg::CFG_LSHIFT: lsc_q   <= cfg_data_i;
        kms_pkg::CFG_RSHIFT: rsc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) map_q[r] <= '0;
      for (int j = 0; j < NL; j++) lane_q[j] <= '0;
      pass_chg_q <= 1'b0;
      commit_q   <= 1'b0;
      row_q      <= '0;
      cur_now_q  <= 1'b0;
      more_q     <= 1'b0;
    end else begin
      if (scan_go) begin
        for (int j = 0; j < NL; j++) begin
          map_q[row_idx][j] <= lane_w[j].now;
          lane_q[j]         <= lane_w[j];
        end
        row_q      <= row_idx;
        pass_chg_q <= last_row ? 1'b0 : (pass_chg_q | any_chg);
        commit_q   <= last_row && (pass_chg_q | any_chg);
      end
      if (lane_clr) begin
        lane_q[pick.col[CW-1:0]].chg <= 1'b0;
        cur_now_q <= pick.now;
        more_q    <= pick.more;
      end
      if (emit && e_kind == kms_pkg::KIND_COMMIT) begin
        commit_q <= 1'b0;
      end
    end
  end

  // shift flags follow emitted key events
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lshift_q <= 1'b0;
      rshift_q <= 1'b0;
    end else if (emit && e_kind == kms_pkg::KIND_KEY) begin
      if (e_code == lsc_q) lshift_q <= e_pressed;
      if (e_code == rsc_q) rshift_q <= e_pressed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= e_kind;
      code_q    <= e_code;
      pressed_q <= e_pressed;
      last_q    <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign key_code_o  = code_q;
  assign pressed_o   = pressed_q;
  assign last_o      = last_q;

  a_read_after_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ($past(state_q) == S_FIND || $past(state_q) == S_READ))
    else $error("keymap lookup without a preceding pick");

  a_idle_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !commit_q)
    else $error("commit marker left pending at idle");

  a_commit_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == kms_pkg::KIND_COMMIT) |-> (last_o && key_code_o == 8'd0))
    else $error("commit marker malformed");

  a_no_emit_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(code_q) && $stable(kind_q) && $stable(last_q)))
    else $error("stalled item overwritten");

  a_esc_then_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ESC && out_free) |=> (out_valid_o && !pressed_o && kind_o == kms_pkg::KIND_KEY))
    else $error("escape release not emitted after tilde release");

endmodule

// ----- test/kms_event_checker.sv -----
// Scoreboard for the keyboard matrix event scanner: tracks key state and checks every result item.
module kms_event_checker
  import kms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       opcode_i,
  input  logic       layer_sel_i,
  input  logic [2:0] row_index_i,
  input  logic [2:0] col_index_i,
  input  logic [7:0] entry_code_i,
  input  logic [7:0] column_bits_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       kind_i,
  input  logic [7:0] key_code_i,
  input  logic       pressed_i,
  input  logic       last_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         mismatches_o,
  output int         pending_o
);

  localparam logic [2:0] LAST_ROW = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [7:0] key_code;
    logic       pressed;
    logic       last;
  } key_event_t;

  logic [63:0] key_state;
  logic [7:0]  keymap [128];   // indexed {layer, row, col}
  logic        lshift_held;
  logic        rshift_held;
  logic        pass_dirty;
  logic [7:0]  escape_code;
  logic [7:0]  tilde_code;
  logic [7:0]  lshift_code;
  logic [7:0]  rshift_code;

  key_event_t  row_events [$];
  key_event_t  expected_events [$];
  int          mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Queues one event of the current row; shift flags follow the emitted key events.
  task automatic add_event(input logic ev_kind, input logic [7:0] code, input logic press);
    key_event_t ev;
    ev.kind     = ev_kind;
    ev.key_code = code;
    ev.pressed  = press;
    ev.last     = 1'b0;
    row_events.push_back(ev);
    if (ev_kind == KIND_KEY) begin
      if (code == lshift_code) lshift_held = press;
      if (code == rshift_code) rshift_held = press;
    end
  endtask

  task automatic predict_row_events(input logic [2:0] row, input logic [7:0] bits);
    int         j;
    logic [2:0] col;
    logic       down;
    logic       layer;
    logic [7:0] code;
    key_event_t ev;
    row_events.delete();
    for (j = 0; j < MAX_COLS; j++) begin
      col   = 3'(j);
      down  = ~bits[j];
      // layer key is read afresh per column, so it can switch mid-row
      layer = key_state[LK_ROW * MAX_COLS + LK_COL];
      code  = keymap[{layer, row, col}];
      if (down != key_state[{row, col}]) begin
        pass_dirty = 1'b1;
        key_state[{row, col}] = down;
        if (down) begin
          if (code == escape_code && (lshift_held || rshift_held)) code = tilde_code;
          add_event(KIND_KEY, code, 1'b1);
        end else begin
          if (code == escape_code) add_event(KIND_KEY, tilde_code, 1'b0);
          add_event(KIND_KEY, code, 1'b0);
        end
      end
    end
    if (row == LAST_ROW && pass_dirty) begin
      pass_dirty = 1'b0;
      add_event(KIND_COMMIT, 8'h00, 1'b0);
    end
    foreach (row_events[i]) begin
      ev = row_events[i];
      ev.last = (i == row_events.size() - 1);
      expected_events.push_back(ev);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_event_t want;
    if (!rst_ni) begin
      key_state   = '0;
      lshift_held = 1'b0;
      rshift_held = 1'b0;
      pass_dirty  = 1'b0;
      escape_code = ESCAPE_RST;
      tilde_code  = TILDE_RST;
      lshift_code = LSHIFT_RST;
      rshift_code = RSHIFT_RST;
      foreach (keymap[i]) keymap[i] = 8'h00;
      expected_events.delete();
    end else begin
      // results here belong to earlier items, so check before predicting
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: kind %0d code %0d",
                                    kind_i, key_code_i));
        end else begin
          want = expected_events.pop_front();
          if (kind_i !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", kind_i, want.kind));
          if (key_code_i !== want.key_code)
            report_mismatch($sformatf("key_code got %0d want %0d", key_code_i, want.key_code));
          if (pressed_i !== want.pressed)
            report_mismatch($sformatf("pressed got %0d want %0d", pressed_i, want.pressed));
          if (last_i !== want.last)
            report_mismatch($sformatf("last got %0d want %0d", last_i, want.last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ESCAPE: escape_code = cfg_data_i;
          CFG_TILDE:  tilde_code  = cfg_data_i;
          CFG_LSHIFT: lshift_code = cfg_data_i;
          CFG_RSHIFT: rshift_code = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (opcode_i == OP_LOAD) keymap[{layer_sel_i, row_index_i, col_index_i}] = entry_code_i;
        else predict_row_events(row_index_i, column_bits_i);
      end
    end
    pending_o    <= expected_events.size();
    mismatches_o <= mismatches;
  end

endmodule

// ----- test/keyboard_matrix_event_scanner_tb.sv -----
// Testbench top of the keyboard matrix event scanner: clock, reset, stimulus and verdict.
module keyboard_matrix_event_scanner_tb;
  import kms_pkg::*;

  localparam int LIMIT = 500000;
  localparam int DRAIN = 40;     // longer than the slowest item

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic       opcode_i      = OP_LOAD;
  logic       layer_sel_i   = 1'b0;
  logic [2:0] row_index_i   = 3'd0;
  logic [2:0] col_index_i   = 3'd0;
  logic [7:0] entry_code_i  = 8'h00;
  logic [7:0] column_bits_i = 8'hFF;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic       kind_o;
  logic [7:0] key_code_o;
  logic       pressed_o;
  logic       last_o;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_index_i   = CFG_ESCAPE;
  logic [7:0] cfg_data_i    = 8'h00;

  int         mismatches;
  int         pending;
  int         cycles        = 0;
  logic       stall_go      = 1'b0;
  logic       no_gaps       = 1'b0;
  logic [7:0] row_bits [8];      // last column readings sent per row
  logic [7:0] cfg_now  [4];      // codes in force, used to bias keymap loads

  keyboard_matrix_event_scanner i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .layer_sel_i   (layer_sel_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .entry_code_i  (entry_code_i),
    .column_bits_i (column_bits_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .key_code_o    (key_code_o),
    .pressed_o     (pressed_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  kms_event_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .layer_sel_i   (layer_sel_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .entry_code_i  (entry_code_i),
    .column_bits_i (column_bits_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_i        (kind_o),
    .key_code_i    (key_code_o),
    .pressed_i     (pressed_o),
    .last_i        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL keyboard_matrix_event_scanner");
      $finish;
    end
  end

  // Receiver pacing: short and long stalls, ready-only bursts, one long hold-off.
  initial begin : rx_pacing
    int   hold;
    int   burst;
    logic stall_done;
    hold       = 0;
    burst      = 0;
    stall_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_go && !stall_done) begin
        stall_done = 1'b1;
        hold       = 400;
        burst      = 0;
      end else if (hold == 0 && burst == 0) begin
        case ($urandom_range(0, 9))
          0:       hold  = $urandom_range(20, 60);
          1, 2:    hold  = $urandom_range(1, 3);
          3:       burst = $urandom_range(50, 200);
          default: ;
        endcase
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (burst > 0) burst--;
      end
    end
  end

  // Offers one item and returns at the edge that accepts it, valid still high.
  task automatic send_item(input logic op, input logic ls, input logic [2:0] r, c,
                           input logic [7:0] code, bits);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0:          gap = $urandom_range(15, 50);
        1, 2, 3:    gap = $urandom_range(1, 4);
        default:    ;
      endcase
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    layer_sel_i   <= ls;
    row_index_i   <= r;
    col_index_i   <= c;
    entry_code_i  <= code;
    column_bits_i <= bits;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic scan_row(input logic [2:0] r, input logic [7:0] bits);
    row_bits[r] = bits;
    send_item(OP_SCAN, 1'($urandom_range(0, 1)), r, 3'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)), bits);
  endtask

  task automatic load_entry(input logic ls, input logic [2:0] r, c, input logic [7:0] code);
    send_item(OP_LOAD, ls, r, c, code, 8'($urandom_range(0, 255)));
  endtask

  // Drops valid, waits for every pending result, then lets any silent item finish.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] esc, tld, lsh, rsh);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ESCAPE;
    cfg_data_i  <= esc;
    @(posedge clk_i);
    cfg_index_i <= CFG_TILDE;
    cfg_data_i  <= tld;
    @(posedge clk_i);
    cfg_index_i <= CFG_LSHIFT;
    cfg_data_i  <= lsh;
    @(posedge clk_i);
    cfg_index_i <= CFG_RSHIFT;
    cfg_data_i  <= rsh;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_now[CFG_ESCAPE] = esc;
    cfg_now[CFG_TILDE]  = tld;
    cfg_now[CFG_LSHIFT] = lsh;
    cfg_now[CFG_RSHIFT] = rsh;
  endtask

  // Odd codes are the ones the fill pattern uses, so they hit real keys.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 255)) | 8'h01;
  endfunction

  initial begin : stimulus
    int         ls;
    int         r;
    int         c;
    int         phase;
    int         sent;
    logic [7:0] code;
    logic [7:0] flip;

    foreach (row_bits[i]) row_bits[i] = 8'hFF;
    cfg_now[CFG_ESCAPE] = ESCAPE_RST;
    cfg_now[CFG_TILDE]  = TILDE_RST;
    cfg_now[CFG_LSHIFT] = LSHIFT_RST;
    cfg_now[CFG_RSHIFT] = RSHIFT_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole keymap first so no scan ever reads an unloaded entry.
    // Row 7 is all escape in both layers; row 0 holds both shifts and an escape.
    for (ls = 0; ls < 2; ls++) begin
      for (r = 0; r < 8; r++) begin
        for (c = 0; c < 8; c++) begin
          code = {1'(ls), 3'(r), 3'(c), 1'b1};
          if (r == 7) code = ESCAPE_RST;
          else if (r == 0 && c == 0) code = LSHIFT_RST;
          else if (r == 0 && c == 1) code = RSHIFT_RST;
          else if (r == 0 && c == 2) code = ESCAPE_RST;
          load_entry(1'(ls), 3'(r), 3'(c), code);
        end
      end
    end

    // Directed: escape with and without shift, full row 7 press and release,
    // commit on changes from other rows, layer switching, extreme codes.
    scan_row(3'd0, 8'hFF);
    scan_row(3'd0, 8'hFB);
    scan_row(3'd0, 8'hFF);
    scan_row(3'd0, 8'hFE);
    scan_row(3'd0, 8'hFA);
    scan_row(3'd0, 8'hFB);
    scan_row(3'd0, 8'hF9);
    scan_row(3'd0, 8'hFF);
    scan_row(3'd7, 8'h00);
    scan_row(3'd7, 8'hFF);
    scan_row(3'd7, 8'hFF);
    scan_row(3'd3, 8'h00);
    scan_row(3'd7, 8'hFF);
    scan_row(3'd7, 8'hBF);
    scan_row(3'd3, 8'hFF);
    scan_row(3'd3, 8'h7F);
    scan_row(3'd7, 8'hFF);
    load_entry(1'b1, 3'd3, 3'd7, 8'h00);
    load_entry(1'b0, 3'd5, 3'd5, 8'hFF);
    scan_row(3'd5, 8'hDF);
    scan_row(3'd5, 8'hFF);
    scan_row(3'd3, 8'hFF);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_config(8'h00, 8'hFF, 8'hFF, 8'h00);
        1:       set_config(ESCAPE_RST, TILDE_RST, LSHIFT_RST, RSHIFT_RST);
        default: set_config(pick_code(), 8'($urandom_range(0, 255)), pick_code(), pick_code());
      endcase
      // phase 1 offers items back to back while the receiver holds off
      no_gaps  = (phase == 1);
      stall_go <= (phase == 1);
      sent = 0;
      while (sent < 20) begin
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 5))
              0:       code = cfg_now[CFG_ESCAPE];
              1:       code = cfg_now[CFG_TILDE];
              2:       code = cfg_now[CFG_LSHIFT];
              3:       code = cfg_now[CFG_RSHIFT];
              default: code = pick_code();
            endcase
            load_entry(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                       3'($urandom_range(0, 7)), code);
            sent++;
          end
          1: begin
            scan_row(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            sent++;
          end
          default: begin
            // a full pass in row order, mostly small changes per row
            for (r = 0; r < 8; r++) begin
              case ($urandom_range(0, 9))
                5, 6, 7: flip = 8'h01 << $urandom_range(0, 7);
                8:       flip = 8'($urandom_range(0, 255));
                9:       flip = (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
                default: flip = 8'h00;
              endcase
              scan_row(3'(r), row_bits[r] ^ flip);
            end
            sent += 8;
          end
        endcase
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS keyboard_matrix_event_scanner");
    end else begin
      $display("FAIL keyboard_matrix_event_scanner");
    end
    $finish;
  end

endmodule
